### rtl/gcf_pkg.sv
// ----------------------------------------------------------------------------
// gcf_pkg
// Types and codes shared by the grouped class FIFO modules.
// ----------------------------------------------------------------------------
package gcf_pkg;

    localparam int CLASS_W  = 2;
    localparam int MEMBER_W = 16;
    localparam int STATUS_W = 2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                func;
        logic [CLASS_W-1:0]  class_id;
        logic [MEMBER_W-1:0] member_id;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_W-1:0]  out_class;
        logic [MEMBER_W-1:0] out_member;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_order_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

### rtl/gcf_member_store.sv
// ----------------------------------------------------------------------------
// gcf_member_store
// Member id memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gcf_member_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/gcf_class_table.sv
// ----------------------------------------------------------------------------
// gcf_class_table
// Per-class pointer memory (head, tail, fill) with registered read data.
// An entry never written reads as zero.
// ----------------------------------------------------------------------------
module gcf_class_table #(
    parameter int NUM_CLASSES = 4,
    parameter int CW          = 2,
    parameter int ENTRY_W     = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CW-1:0]      i_rd_addr,
    input  logic               i_rd_en,
    input  logic               i_wr_en,
    input  logic [CW-1:0]      i_wr_addr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0]     r_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_vld;
    logic [ENTRY_W-1:0]     r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### rtl/gcf_order_list.sv
// ----------------------------------------------------------------------------
// gcf_order_list
// Service order of non-empty classes: append into the first free slot,
// pop the front slot and shift the rest forward.
// ----------------------------------------------------------------------------
module gcf_order_list #(
    parameter int NUM_CLASSES = 4,
    parameter int CW          = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gcf_pkg::t_order_cmd i_cmd,
    input  logic [CW-1:0]       i_push_cls,
    output logic [CW-1:0]       o_head_cls,
    output logic                o_head_vld
);

    logic [CW-1:0]          r_cls [NUM_CLASSES];
    logic [CW-1:0]          n_cls [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_vld;
    logic [NUM_CLASSES-1:0] n_vld;
    logic                   found;

    always_comb begin
        n_cls = r_cls;
        n_vld = r_vld;
        found = 1'b0;
        if (i_cmd.pop) begin
            for (int s = 0; s < NUM_CLASSES - 1; s++) begin
                n_cls[s] = r_cls[s+1];
                n_vld[s] = r_vld[s+1];
            end
            n_cls[NUM_CLASSES-1] = '0;
            n_vld[NUM_CLASSES-1] = 1'b0;
        end else if (i_cmd.push) begin
            for (int s = 0; s < NUM_CLASSES; s++) begin
                if (!found && !r_vld[s]) begin
                    n_vld[s] = 1'b1;
                    n_cls[s] = i_push_cls;
                    found    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls <= n_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_head_cls = r_cls[0];
    assign o_head_vld = r_vld[0];

endmodule

### rtl/grouped_class_fifo.sv
// ----------------------------------------------------------------------------
// grouped_class_fifo
// Grouped FIFO: per-class member queues served in the order classes
// first became non-empty.
// ----------------------------------------------------------------------------
// For each item, busy is high in the cycle after start is
// taken, while the per-class pointer entry read in the accept cycle is updated
// and written back and the member memory is written or read. A result (dequeued
// member, empty status, or dropped enqueue) shows on o_result with o_done high
// for exactly one cycle, the cycle in which busy falls; it cannot be held off, and
// a new item may be started in that same cycle. A successful enqueue and an
// enqueue to a class at or beyond NUM_CLASSES give no result. Storage is one
// memory of NUM_CLASSES*CLASS_DEPTH member ids plus a NUM_CLASSES-entry
// pointer table; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module grouped_class_fifo #(
    parameter int NUM_CLASSES = 4,
    parameter int CLASS_DEPTH = 256,
    parameter int ID_BITS     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gcf_pkg::t_in_item i_item,
    output logic              o_done,
    output gcf_pkg::t_out_item o_result
);

    localparam int CW      = $clog2(NUM_CLASSES);
    localparam int PW      = $clog2(CLASS_DEPTH);
    localparam int FW      = $clog2(CLASS_DEPTH + 1);
    localparam int AW      = $clog2(NUM_CLASSES * CLASS_DEPTH);
    localparam int SW      = (ID_BITS < gcf_pkg::MEMBER_W) ? ID_BITS : gcf_pkg::MEMBER_W;
    localparam int ENTRY_W = 2 * PW + FW;

    localparam logic [PW-1:0] PTR_LAST  = PW'(CLASS_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(CLASS_DEPTH);
    localparam logic [AW-1:0] BASE_STEP = AW'(CLASS_DEPTH);

    gcf_pkg::t_state r_state;
    gcf_pkg::t_state n_state;

    // item held during the update cycle
    logic          r_func;
    logic [CW-1:0] r_cls;
    logic          r_cls_ok;
    logic          r_head_vld;
    logic [SW-1:0] r_member;

    // result registers
    logic                          r_done;
    logic [gcf_pkg::CLASS_W-1:0]   r_res_class;
    logic [gcf_pkg::STATUS_W-1:0]  r_res_status;
    logic [gcf_pkg::MEMBER_W-1:0]  r_res_member;
    logic                          r_from_mem;

    logic                          accept;
    logic                          upd;
    logic [CW-1:0]                 in_cls;
    logic                          in_cls_ok;
    logic [CW-1:0]                 head_cls;
    logic                          head_vld;
    logic [CW-1:0]                 rd_cls;

    logic [ENTRY_W-1:0]            tbl_rd;
    logic [ENTRY_W-1:0]            tbl_wr;
    logic                          tbl_we;
    logic [PW-1:0]                 head_ptr;
    logic [PW-1:0]                 tail_ptr;
    logic [FW-1:0]                 fill;
    logic [PW-1:0]                 n_head_ptr;
    logic [PW-1:0]                 n_tail_ptr;
    logic [FW-1:0]                 n_fill;

    logic                          enq_ok;
    logic                          enq_full;
    logic                          deq_ok;
    logic                          deq_empty;
    logic [AW-1:0]                 base;
    logic                          mem_we;
    logic                          mem_re;
    logic [AW-1:0]                 mem_addr;
    logic [SW-1:0]                 mem_rd;
    gcf_pkg::t_order_cmd           order_cmd;

    logic                          n_done;
    logic [gcf_pkg::CLASS_W-1:0]   n_res_class;
    logic [gcf_pkg::STATUS_W-1:0]  n_res_status;
    logic [gcf_pkg::MEMBER_W-1:0]  n_res_member;
    logic                          n_from_mem;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcf_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = gcf_pkg::ST_UPDATE;
                end
            end
            gcf_pkg::ST_UPDATE: begin
                n_state = gcf_pkg::ST_IDLE;
            end
            default: begin
                n_state = gcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy   = 1'b0;
        accept = 1'b0;
        upd    = 1'b0;
        case (r_state)
            gcf_pkg::ST_IDLE: begin
                accept = start;
            end
            gcf_pkg::ST_UPDATE: begin
                busy = 1'b1;
                upd  = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- accept: look up the class entry ----------------
    assign in_cls    = CW'(i_item.class_id);
    assign in_cls_ok = int'(i_item.class_id) < NUM_CLASSES;
    assign rd_cls    = (i_item.func == gcf_pkg::FUNC_ENQ) ? in_cls : head_cls;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= i_item.func;
            r_cls      <= rd_cls;
            r_cls_ok   <= in_cls_ok;
            r_head_vld <= head_vld;
            r_member   <= SW'(i_item.member_id);
        end
    end

    gcf_class_table #(
        .NUM_CLASSES (NUM_CLASSES),
        .CW          (CW),
        .ENTRY_W     (ENTRY_W)
    ) u_class_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_cls),
        .i_rd_en   (accept),
        .i_wr_en   (tbl_we),
        .i_wr_addr (r_cls),
        .i_wr_data (tbl_wr),
        .o_rd_data (tbl_rd)
    );

    // ---------------- update: modify and write back ----------------
    assign head_ptr = tbl_rd[ENTRY_W-1 -: PW];
    assign tail_ptr = tbl_rd[FW +: PW];
    assign fill     = tbl_rd[FW-1:0];

    assign enq_ok    = upd && (r_func == gcf_pkg::FUNC_ENQ) && r_cls_ok && (fill < FILL_FULL);
    assign enq_full  = upd && (r_func == gcf_pkg::FUNC_ENQ) && r_cls_ok && (fill >= FILL_FULL);
    assign deq_ok    = upd && (r_func == gcf_pkg::FUNC_DEQ) && r_head_vld && (fill != '0);
    assign deq_empty = upd && (r_func == gcf_pkg::FUNC_DEQ) && !(r_head_vld && (fill != '0));

    always_comb begin
        n_head_ptr = head_ptr;
        n_tail_ptr = tail_ptr;
        n_fill     = fill;
        if (enq_ok) begin
            n_tail_ptr = (tail_ptr == PTR_LAST) ? '0 : tail_ptr + 1'b1;
            n_fill     = fill + 1'b1;
        end else if (deq_ok) begin
            n_head_ptr = (head_ptr == PTR_LAST) ? '0 : head_ptr + 1'b1;
            n_fill     = fill - 1'b1;
        end
    end

    assign tbl_we = enq_ok || deq_ok;
    assign tbl_wr = {n_head_ptr, n_tail_ptr, n_fill};

    assign base     = AW'(r_cls) * BASE_STEP;
    assign mem_addr = base + AW'(enq_ok ? tail_ptr : head_ptr);
    assign mem_we   = enq_ok;
    assign mem_re   = deq_ok;

    gcf_member_store #(
        .DEPTH  (NUM_CLASSES * CLASS_DEPTH),
        .ADDR_W (AW),
        .DATA_W (SW)
    ) u_member_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_addr),
        .i_wr_data (r_member),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_addr),
        .o_rd_data (mem_rd)
    );

    // join the order list when a class turns non-empty, leave it when it drains
    assign order_cmd.push = enq_ok && (fill == '0);
    assign order_cmd.pop  = deq_ok && (fill == FW'(1));

    gcf_order_list #(
        .NUM_CLASSES (NUM_CLASSES),
        .CW          (CW)
    ) u_order_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (order_cmd),
        .i_push_cls (r_cls),
        .o_head_cls (head_cls),
        .o_head_vld (head_vld)
    );

    // ---------------- result ----------------
    always_comb begin
        n_done       = 1'b0;
        n_res_class  = '0;
        n_res_status = gcf_pkg::STAT_OK;
        n_res_member = '0;
        n_from_mem   = 1'b0;
        if (deq_ok) begin
            n_done      = 1'b1;
            n_res_class = gcf_pkg::CLASS_W'(r_cls);
            n_from_mem  = 1'b1;
        end else if (deq_empty) begin
            n_done       = 1'b1;
            n_res_status = gcf_pkg::STAT_EMPTY;
        end else if (enq_full) begin
            n_done       = 1'b1;
            n_res_class  = gcf_pkg::CLASS_W'(r_cls);
            n_res_status = gcf_pkg::STAT_FULL;
            n_res_member = gcf_pkg::MEMBER_W'(r_member);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_class  <= n_res_class;
        r_res_status <= n_res_status;
        r_res_member <= n_res_member;
        r_from_mem   <= n_from_mem;
    end

    assign o_done              = r_done;
    assign o_result.out_class  = r_res_class;
    assign o_result.status     = r_res_status;
    assign o_result.out_member = r_from_mem ? gcf_pkg::MEMBER_W'(mem_rd) : r_res_member;

endmodule

### tb/sv/gcf_checker.sv
// ----------------------------------------------------------------------------
// gcf_checker
// Watches the command and result channels of grouped_class_fifo, predicts
// every result from its own copy of the class queues and the service order,
// and compares each result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module gcf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  gcf_pkg::t_in_item  i_item,
    input  logic               i_done,
    input  gcf_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_stored
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASSES = 4;
    localparam int DEPTH   = 256;

    // Per-class circular member buffers
    logic [gcf_pkg::MEMBER_W-1:0] stash [CLASSES][DEPTH];
    int                           rd_pos [CLASSES];
    int                           wr_pos [CLASSES];
    int                           held   [CLASSES];
    int                           total_held;

    // Service order: class in each turn slot, slot 0 is served next
    logic [gcf_pkg::CLASS_W-1:0]  turn_cls [CLASSES];
    logic                         turn_vld [CLASSES];

    gcf_pkg::t_out_item           owed_results [$];
    gcf_pkg::t_out_item           want;
    int                           fails = 0;

    task automatic serve_op(input gcf_pkg::t_in_item it);
        int                 c;
        bit                 emits;
        gcf_pkg::t_out_item r;
        emits = 1'b0;
        r     = '0;
        if (it.func == gcf_pkg::FUNC_ENQ) begin
            c = int'(it.class_id);
            if (held[c] == DEPTH) begin
                // drop: class queue is full
                r.out_class  = it.class_id;
                r.out_member = it.member_id;
                r.status     = gcf_pkg::STAT_FULL;
                emits        = 1'b1;
            end else begin
                stash[c][wr_pos[c]] = it.member_id;
                wr_pos[c] = (wr_pos[c] + 1) % DEPTH;
                held[c]++;
                total_held++;
                // a class that just became non-empty takes the first free turn slot
                if (held[c] == 1) begin
                    for (int s = 0; s < CLASSES; s++) begin
                        if (!turn_vld[s]) begin
                            turn_vld[s] = 1'b1;
                            turn_cls[s] = it.class_id;
                            break;
                        end
                    end
                end
            end
        end else begin
            emits = 1'b1;
            if (!turn_vld[0]) begin
                r.status = gcf_pkg::STAT_EMPTY;
            end else begin
                c            = int'(turn_cls[0]);
                r.out_class  = turn_cls[0];
                r.out_member = stash[c][rd_pos[c]];
                r.status     = gcf_pkg::STAT_OK;
                rd_pos[c]    = (rd_pos[c] + 1) % DEPTH;
                held[c]--;
                total_held--;
                // class emptied: advance the remaining turns
                if (held[c] == 0) begin
                    for (int s = 0; s < CLASSES - 1; s++) begin
                        turn_cls[s] = turn_cls[s + 1];
                        turn_vld[s] = turn_vld[s + 1];
                    end
                    turn_cls[CLASSES - 1] = '0;
                    turn_vld[CLASSES - 1] = 1'b0;
                end
            end
        end
        if (emits) begin
            owed_results = {owed_results, r};
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLASSES; k++) begin
                rd_pos[k]   = 0;
                wr_pos[k]   = 0;
                held[k]     = 0;
                turn_cls[k] = '0;
                turn_vld[k] = 1'b0;
            end
            total_held = 0;
            owed_results.delete();
        end else begin
            // check the finished result before taking a new item in the same cycle
            if (i_done) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: out_class %0d out_member %0h status %0d",
                           i_result.out_class, i_result.out_member, i_result.status);
                    fails++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_result.out_class !== want.out_class) begin
                        $error("out_class: expected %0d, got %0d",
                               want.out_class, i_result.out_class);
                        fails++;
                    end
                    if (i_result.out_member !== want.out_member) begin
                        $error("out_member: expected %0h, got %0h",
                               want.out_member, i_result.out_member);
                        fails++;
                    end
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_result.status);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                serve_op(i_item);
            end
        end
        o_pending    <= owed_results.size();
        o_stored     <= total_held;
        o_fail_count <= fails;
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for grouped_class_fifo: a directed run through empty dequeues,
// class service order and rejoining classes, then random mixes of enqueues
// and dequeues with class floods to overflow, drains and sender pauses.
// Checking is done by gcf_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS     = 1750;
    localparam int QUIET_TAIL  = 250;
    localparam int STALL_LIMIT = 1000;
    localparam int FLOOD_DEPTH = 256;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    gcf_pkg::t_in_item  i_item  = '0;
    logic               o_done;
    gcf_pkg::t_out_item o_result;

    int        fail_count;
    int        pending;
    int        stored;
    int        sent        = 0;
    int        idle_cycles = 0;
    bit        idle_on     = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    grouped_class_fifo uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    gcf_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_done      (o_done),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_stored    (stored)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [gcf_pkg::MEMBER_W-1:0] pick_member();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return gcf_pkg::MEMBER_W'($urandom);
            end
        endcase
    endfunction

    // Drive one item and hold it until the block takes it
    task automatic send_op(input logic f, input logic [gcf_pkg::CLASS_W-1:0] c,
                           input logic [gcf_pkg::MEMBER_W-1:0] m);
        gcf_pkg::t_in_item it;
        it.func      = f;
        it.class_id  = c;
        it.member_id = m;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic flood_class(input logic [gcf_pkg::CLASS_W-1:0] c);
        repeat (FLOOD_DEPTH + $urandom_range(1, 4)) begin
            send_op(gcf_pkg::FUNC_ENQ, c, pick_member());
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int                          mode;
        int                          len;
        int                          enq_pct;
        bit                          narrow;
        logic [gcf_pkg::CLASS_W-1:0] ca;
        logic [gcf_pkg::CLASS_W-1:0] cb;
        logic [gcf_pkg::CLASS_W-1:0] c;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dequeue from an empty block
        send_op(gcf_pkg::FUNC_DEQ, 2'd3, 16'hFFFF);
        // classes join the order in arrival order, extremes of the member id
        send_op(gcf_pkg::FUNC_ENQ, 2'd0, 16'h0000);
        send_op(gcf_pkg::FUNC_ENQ, 2'd3, 16'hFFFF);
        send_op(gcf_pkg::FUNC_ENQ, 2'd1, 16'h1234);
        send_op(gcf_pkg::FUNC_ENQ, 2'd0, 16'hABCD);
        send_op(gcf_pkg::FUNC_ENQ, 2'd2, 16'h5555);
        repeat (6) begin
            send_op(gcf_pkg::FUNC_DEQ, 2'd0, 16'h0000);
        end
        // an emptied class rejoins behind the classes still waiting
        send_op(gcf_pkg::FUNC_ENQ, 2'd2, 16'hAAAA);
        send_op(gcf_pkg::FUNC_ENQ, 2'd1, 16'h8001);
        send_op(gcf_pkg::FUNC_DEQ, 2'd1, 16'h7FFE);
        send_op(gcf_pkg::FUNC_ENQ, 2'd2, 16'h00FF);
        send_op(gcf_pkg::FUNC_DEQ, 2'd2, 16'hFF00);
        send_op(gcf_pkg::FUNC_DEQ, 2'd0, 16'h0000);
        send_op(gcf_pkg::FUNC_DEQ, 2'd3, 16'hFFFF);
        wait_drained();

        // fill one class past its depth early so overflow is always seen
        idle_on = 1'b1;
        flood_class(2'($urandom_range(0, 3)));

        while (sent < N_ITEMS) begin
            idle_on = (sent < N_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            mode    = $urandom_range(0, 23);
            if (mode == 0) begin
                flood_class(2'($urandom_range(0, 3)));
            end else if (mode <= 3) begin
                // drain everything, then one dequeue more
                while (stored != 0) begin
                    send_op(gcf_pkg::FUNC_DEQ, 2'($urandom_range(0, 3)), pick_member());
                end
                send_op(gcf_pkg::FUNC_DEQ, 2'($urandom_range(0, 3)), pick_member());
            end else if (mode == 4) begin
                wait_drained();
            end else begin
                len     = $urandom_range(10, 60);
                enq_pct = (mode < 14) ? 70 : 45;
                narrow  = 1'($urandom_range(0, 1));
                ca      = 2'($urandom_range(0, 3));
                cb      = 2'($urandom_range(0, 3));
                repeat (len) begin
                    c = narrow ? ($urandom_range(0, 1) ? ca : cb) : 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 99) < enq_pct) begin
                        send_op(gcf_pkg::FUNC_ENQ, c, pick_member());
                    end else begin
                        send_op(gcf_pkg::FUNC_DEQ, c, pick_member());
                    end
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
